// ----- design/arst_pkg.sv -----
// Package for the address range segment table: sizes, codes and request/result types.
`timescale 1ns / 1ps
`default_nettype none
package arst_pkg;

    localparam int SEG_DEPTH = 64;
    localparam int IDX_W     = $clog2(SEG_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int ADDR_W    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOGAP   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] range_address;
        logic [31:0]       range_length;
        logic [7:0]        range_flags;
    } t_in_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] found_address;
        logic [6:0]        segment_count;
    } t_out_rsp;

    // one table entry; the inclusive last address is kept instead of the length
    typedef struct packed {
        logic [ADDR_W-1:0] seg_start;
        logic [ADDR_W-1:0] seg_last;
        logic [7:0]        seg_prot;
    } t_seg;

endpackage
`default_nettype wire

// ----- design/arst_mem.sv -----
// Segment table storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module arst_mem
    import arst_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_seg             i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_seg                  o_rdata
);

    t_seg r_mem [SEG_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- design/address_range_segment_table.sv -----
// Top level of the address range segment table: request sequencer around the table memory.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  request | in        | i_in_valid / o_in_ready  | i_in_req  (t_in_req)
//  result  | out       | o_out_valid / i_out_ready| o_out_rsp (t_out_rsp)
//
// One request at a time; each table step is a read state and an evaluate state.
// Insert walks to its slot, shifts later entries up and writes; remove scans, then
// compacts, or shifts and writes both pieces of a split; find walks for a gap.
// Empty-table remove/find, zero-length insert/remove and unknown ops skip the table.
// Reset (synchronous, active low) empties the table; entries are not cleared.
// A request is taken while a result waits; its result then holds until the output frees.
`timescale 1ns / 1ps
`default_nettype none
module address_range_segment_table
    import arst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_req  i_in_req,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_rsp      o_out_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_EV, S_INS_CHK, S_SH_RD, S_SH_WR, S_INS_PUT,
        S_RM_RD, S_RM_EV, S_SPL_PUT1, S_SPL_PUT2, S_CP_RD, S_CP_EV,
        S_FD_RD, S_FD_EV, S_DONE
    } t_state;

    t_state            r_state;
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_addr;       // request start
    logic [31:0]       r_len;
    logic [7:0]        r_prot;
    logic [ADDR_W-1:0] r_last;       // insert: last byte; remove: clipped last byte
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;        // walk pointer
    logic [IDX_W-1:0]  r_w;          // compaction write pointer
    logic [CNT_W-1:0]  r_k;          // shift destination
    logic [CNT_W-1:0]  r_p;          // insertion / split slot
    logic              r_have_prev;
    logic [ADDR_W-1:0] r_prev_last;
    logic              r_has_next;
    logic [ADDR_W-1:0] r_next_start;
    t_seg              r_sv;         // segment being split
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_found;
    logic              r_out_valid;
    t_out_rsp          r_out;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_seg              mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    t_seg              mem_rdata;

    logic              in_acc;
    logic [ADDR_W-1:0] len_m1;
    logic              past_top;
    logic [CNT_W-1:0]  k_m1;
    logic [CNT_W-1:0]  p_m1;
    logic              idx_last;
    logic              cp_keep;
    t_seg              cp_seg;
    logic [ADDR_W-1:0] fd_gap;
    logic [ADDR_W-1:0] fd_tail;

    assign in_acc   = i_in_valid && o_in_ready;
    assign len_m1   = i_in_req.range_length - 32'd1;
    assign past_top = len_m1 > ~i_in_req.range_address;
    assign k_m1     = r_k - CNT_W'(1);
    assign p_m1     = r_p - CNT_W'(1);
    assign idx_last = ({1'b0, r_idx} + CNT_W'(1)) == r_count;
    assign fd_gap   = mem_rdata.seg_start - r_prev_last - ADDR_W'(1);
    assign fd_tail  = ~mem_rdata.seg_last;

    // compaction: keep, trim front, trim tail or drop the entry just read
    always_comb begin
        cp_seg  = mem_rdata;
        cp_keep = 1'b1;
        priority if (mem_rdata.seg_last < r_addr || mem_rdata.seg_start > r_last) begin
            cp_keep = 1'b1;
        end else if (mem_rdata.seg_start < r_addr) begin
            cp_seg.seg_last = r_addr - ADDR_W'(1);
        end else if (mem_rdata.seg_last > r_last) begin
            cp_seg.seg_start = r_last + ADDR_W'(1);
        end else begin
            cp_keep = 1'b0;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_raddr = r_idx;
        unique case (r_state)
            S_SH_RD: mem_raddr = k_m1[IDX_W-1:0];
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[IDX_W-1:0];
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_p[IDX_W-1:0];
                mem_wdata = '{seg_start: r_addr, seg_last: r_last, seg_prot: r_prot};
            end
            S_SPL_PUT1: begin
                mem_we    = 1'b1;
                mem_waddr = r_p[IDX_W-1:0];
                mem_wdata = '{seg_start: r_last + ADDR_W'(1), seg_last: r_sv.seg_last,
                              seg_prot: r_sv.seg_prot};
            end
            S_SPL_PUT2: begin
                mem_we    = 1'b1;
                mem_waddr = p_m1[IDX_W-1:0];
                mem_wdata = '{seg_start: r_sv.seg_start, seg_last: r_addr - ADDR_W'(1),
                              seg_prot: r_sv.seg_prot};
            end
            S_CP_EV: begin
                mem_we    = cp_keep;
                mem_waddr = r_w;
                mem_wdata = cp_seg;
            end
            default: mem_raddr = r_idx;
        endcase
    end

    arst_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op        <= i_in_req.operation;
                        r_addr      <= i_in_req.range_address;
                        r_len       <= i_in_req.range_length;
                        r_prot      <= i_in_req.range_flags;
                        r_status    <= ST_OK;
                        r_found     <= '0;
                        r_idx       <= '0;
                        r_w         <= '0;
                        r_have_prev <= 1'b0;
                        r_state     <= S_DONE;
                        unique case (t_op'(i_in_req.operation))
                            OP_INSERT: begin
                                r_last <= i_in_req.range_address + len_m1;
                                if (i_in_req.range_length == 32'd0) begin
                                    r_state <= S_DONE;
                                end else if (past_top) begin
                                    r_status <= ST_OVERLAP;
                                end else if (r_count == '0) begin
                                    r_p        <= '0;
                                    r_has_next <= 1'b0;
                                    r_state    <= S_INS_CHK;
                                end else begin
                                    r_state <= S_INS_RD;
                                end
                            end
                            OP_REMOVE: begin
                                r_last <= past_top ? '1 : i_in_req.range_address + len_m1;
                                if (i_in_req.range_length != 32'd0 && r_count != '0) begin
                                    r_state <= S_RM_RD;
                                end
                            end
                            OP_FIND: begin
                                if (r_count == '0) begin
                                    r_status <= ST_NOGAP;
                                end else begin
                                    r_state <= S_FD_RD;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_INS_RD: r_state <= S_INS_EV;
                S_INS_EV: begin
                    if (mem_rdata.seg_start < r_addr) begin
                        r_have_prev <= 1'b1;
                        r_prev_last <= mem_rdata.seg_last;
                        r_idx       <= r_idx + IDX_W'(1);
                        if (idx_last) begin
                            r_p        <= r_count;
                            r_has_next <= 1'b0;
                            r_state    <= S_INS_CHK;
                        end else begin
                            r_state <= S_INS_RD;
                        end
                    end else begin
                        r_p          <= {1'b0, r_idx};
                        r_has_next   <= 1'b1;
                        r_next_start <= mem_rdata.seg_start;
                        r_state      <= S_INS_CHK;
                    end
                end
                S_INS_CHK: begin
                    priority if ((r_have_prev && r_prev_last >= r_addr) ||
                                 (r_has_next && r_next_start <= r_last)) begin
                        r_status <= ST_OVERLAP;
                        r_state  <= S_DONE;
                    end else if (r_count >= CNT_W'(SEG_DEPTH)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_k     <= r_count;
                        r_state <= (r_count == r_p) ? S_INS_PUT : S_SH_RD;
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_k <= k_m1;
                    if (k_m1 == r_p) begin
                        r_state <= (r_op == OP_INSERT) ? S_INS_PUT : S_SPL_PUT1;
                    end else begin
                        r_state <= S_SH_RD;
                    end
                end
                S_INS_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_RM_RD: r_state <= S_RM_EV;
                S_RM_EV: begin
                    if (mem_rdata.seg_start < r_addr && mem_rdata.seg_last > r_last) begin
                        if (r_count >= CNT_W'(SEG_DEPTH)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_sv    <= mem_rdata;
                            r_p     <= {1'b0, r_idx} + CNT_W'(1);
                            r_k     <= r_count;
                            r_state <= (r_count == {1'b0, r_idx} + CNT_W'(1)) ?
                                       S_SPL_PUT1 : S_SH_RD;
                        end
                    end else if (idx_last) begin
                        r_idx   <= '0;
                        r_state <= S_CP_RD;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RM_RD;
                    end
                end
                S_SPL_PUT1: r_state <= S_SPL_PUT2;
                S_SPL_PUT2: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_CP_RD: r_state <= S_CP_EV;
                S_CP_EV: begin
                    if (cp_keep) begin
                        r_w <= r_w + IDX_W'(1);
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (idx_last) begin
                        r_count <= {1'b0, r_w} + CNT_W'(cp_keep);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CP_RD;
                    end
                end
                S_FD_RD: r_state <= S_FD_EV;
                S_FD_EV: begin
                    r_prev_last <= mem_rdata.seg_last;
                    r_idx       <= r_idx + IDX_W'(1);
                    priority if (r_idx != '0 && fd_gap >= r_len) begin
                        r_found <= r_prev_last + ADDR_W'(1);
                        r_state <= S_DONE;
                    end else if (idx_last) begin
                        if (fd_tail >= r_len) begin
                            r_found <= mem_rdata.seg_last + ADDR_W'(1);
                        end else begin
                            r_status <= ST_NOGAP;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FD_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{status: r_status, found_address: r_found,
                                         segment_count: r_count};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule
`default_nettype wire

// ----- design/arst_checker.sv -----
// Port-level checker for the address range segment table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module arst_checker
    import arst_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_out_rsp o_out_rsp
);

    // a result waiting on the output holds steady
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("result changed while stalled");

    // one request at a time: the sequencer is busy right after taking one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_rsp.segment_count <= 7'(SEG_DEPTH))
        else $error("segment count beyond table depth");

    a_nogap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.status == ST_NOGAP |-> o_out_rsp.found_address == '0)
        else $error("address reported without a gap");

endmodule

bind address_range_segment_table arst_checker u_arst_checker (.*);
`default_nettype wire
